@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ rtl/brl_pkg.sv @@
package brl_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int SCREEN_BITS    = 15;
  localparam int CFG_IDX_BITS   = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = 15'd1024;
  localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = 15'd768;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // command queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_LOAD,
    CMD_DROP
  } cmd_kind_t;

  typedef struct packed {
    logic      valid;
    cmd_kind_t kind;
  } cmd_hdr_t;

endpackage

@@ rtl/brl_front.sv @@
module brl_front #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  logic                          req_type,
  input  logic signed [COORD_BITS-1:0]  start_x,
  input  logic signed [COORD_BITS-1:0]  start_y,
  input  logic signed [COORD_BITS-1:0]  end_x,
  input  logic signed [COORD_BITS-1:0]  end_y,
  input  logic                          end_is_wall,
  input  logic                          in_valid,
  output logic                          in_ready,
  output brl_pkg::cmd_hdr_t             cmd_hdr,
  output logic [7*COORD_BITS+5:0]       cmd_payload,
  input  logic                          cmd_ready
);
  import brl_pkg::*;

  localparam int C = COORD_BITS;

  logic signed [C:0]   diff_x;
  logic signed [C:0]   diff_y;
  logic        [C:0]   abs_dx;
  logic        [C:0]   abs_dy;
  logic                step_x_neg;
  logic                step_y_neg;
  logic signed [C+1:0] err_init;

  always_comb begin
    diff_x     = (C+1)'(end_x) - (C+1)'(start_x);
    diff_y     = (C+1)'(end_y) - (C+1)'(start_y);
    abs_dx     = diff_x[C] ? (C+1)'(-diff_x) : diff_x;
    abs_dy     = diff_y[C] ? (C+1)'(-diff_y) : diff_y;
    step_x_neg = diff_x[C] || (diff_x == '0);
    step_y_neg = diff_y[C] || (diff_y == '0);
    // halving a nonnegative magnitude truncates toward zero
    if (abs_dx > abs_dy) begin
      err_init = signed'({2'b00, abs_dx[C:1]});
    end else begin
      err_init = -signed'({2'b00, abs_dy[C:1]});
    end
  end

  always_comb begin
    cmd_hdr.valid = in_valid;
    if (req_type == REQ_TICK) begin
      cmd_hdr.kind = CMD_TICK;
    end else if (end_is_wall) begin
      cmd_hdr.kind = CMD_DROP;
    end else begin
      cmd_hdr.kind = CMD_LOAD;
    end
    cmd_payload = {err_init, step_y_neg, step_x_neg, abs_dy, abs_dx,
                   end_y, end_x, start_y, start_x};
  end

  assign in_ready = cmd_ready;

endmodule

@@ rtl/brl_cmd_fifo.sv @@
`include "assert_macros.svh"

module brl_cmd_fifo #(
  parameter int DATA_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  brl_pkg::cmd_hdr_t     wr_hdr,
  input  logic [DATA_BITS-1:0]  wr_data,
  output logic                  wr_ready,
  output brl_pkg::cmd_hdr_t     rd_hdr,
  output logic [DATA_BITS-1:0]  rd_data,
  input  logic                  rd_pop
);
  import brl_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int ENT_W = DATA_BITS + $bits(cmd_kind_t);
  localparam logic [PTR_W:0] CNT_ONE = (PTR_W+1)'(1);

  logic [ENT_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != (PTR_W+1)'(QUEUE_DEPTH));
  assign push     = wr_hdr.valid && wr_ready;
  assign pop      = rd_pop && (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= {wr_hdr.kind, wr_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

  always_comb begin
    rd_hdr.valid = (count != '0);
    rd_hdr.kind  = cmd_kind_t'(mem[rd_ptr][ENT_W-1:DATA_BITS]);
    rd_data      = mem[rd_ptr][DATA_BITS-1:0];
  end

  `ASSERT_RST(a_count_bound, clk, rst, count <= (PTR_W+1)'(QUEUE_DEPTH), "queue overfilled")
  `ASSERT_RST(a_push_grows, clk, rst, push && !pop |=> count == $past(count) + CNT_ONE, "push lost")
  `ASSERT_RST(a_pop_shrinks, clk, rst, pop && !push |=> count == $past(count) - CNT_ONE, "pop lost")

endmodule

@@ rtl/brl_back.sv @@
`include "assert_macros.svh"

module brl_back #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [brl_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  logic [brl_pkg::SCREEN_BITS-1:0]    cfg_wdata,
  input  brl_pkg::cmd_hdr_t                  cmd_hdr,
  input  logic [7*COORD_BITS+5:0]            cmd_payload,
  output logic                               cmd_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [COORD_BITS-1:0]       pixel_x,
  output logic signed [COORD_BITS-1:0]       pixel_y,
  output logic                               on_screen,
  output logic                               last_pixel
);
  import brl_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int CMP_W = ((C > SCREEN_BITS) ? C : SCREEN_BITS) + 1;

  logic [SCREEN_BITS-1:0] screen_width;
  logic [SCREEN_BITS-1:0] screen_height;

  logic [C-1:0]        cur_x;
  logic [C-1:0]        cur_y;
  logic [C-1:0]        target_x;
  logic [C-1:0]        target_y;
  logic [C:0]          abs_dx;
  logic [C:0]          abs_dy;
  logic                step_x_neg;
  logic                step_y_neg;
  logic signed [C+1:0] error_term;
  logic                line_active;

  logic                out_free;
  logic                emit;
  logic                at_end;
  logic                vis;
  logic                move_x;
  logic                move_y;
  logic signed [C+1:0] dx_s;
  logic signed [C+1:0] dy_s;
  logic signed [C+1:0] err_next;
  logic [C-1:0]        cur_x_next;
  logic [C-1:0]        cur_y_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      if (cfg_idx == CFG_SCREEN_WIDTH) begin
        screen_width <= cfg_wdata;
      end else if (cfg_idx == CFG_SCREEN_HEIGHT) begin
        screen_height <= cfg_wdata;
      end
    end
  end

  // a tick on an active line needs room in the output register
  assign out_free = !out_valid || out_ready;
  assign cmd_pop  = cmd_hdr.valid &&
                    (cmd_hdr.kind != CMD_TICK || !line_active || out_free);
  assign emit     = cmd_pop && cmd_hdr.kind == CMD_TICK && line_active;

  always_comb begin
    at_end = (cur_x == target_x) && (cur_y == target_y);
    vis = !cur_x[C-1] && (cur_x != '0) && !cur_y[C-1] && (cur_y != '0) &&
          ({{(CMP_W-C){1'b0}}, cur_x} < {{(CMP_W-SCREEN_BITS){1'b0}}, screen_width}) &&
          ({{(CMP_W-C){1'b0}}, cur_y} < {{(CMP_W-SCREEN_BITS){1'b0}}, screen_height});
    dx_s   = signed'({1'b0, abs_dx});
    dy_s   = signed'({1'b0, abs_dy});
    move_x = error_term > -dx_s;
    move_y = error_term < dy_s;
    err_next = error_term - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
    cur_x_next = move_x ? (step_x_neg ? cur_x - C'(1) : cur_x + C'(1)) : cur_x;
    cur_y_next = move_y ? (step_y_neg ? cur_y - C'(1) : cur_y + C'(1)) : cur_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (cmd_pop) begin
      case (cmd_hdr.kind)
        CMD_LOAD: line_active <= 1'b1;
        CMD_DROP: line_active <= 1'b0;
        CMD_TICK: begin
          if (line_active && at_end) begin
            line_active <= 1'b0;
          end
        end
        default: line_active <= line_active;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd_hdr.kind == CMD_LOAD) begin
      {error_term, step_y_neg, step_x_neg, abs_dy, abs_dx,
       target_y, target_x, cur_y, cur_x} <= cmd_payload;
    end else if (emit && !at_end) begin
      error_term <= err_next;
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x    <= signed'(cur_x);
      pixel_y    <= signed'(cur_y);
      on_screen  <= vis;
      last_pixel <= at_end;
    end
  end

  `ASSERT_RST(a_drop_idles, clk, rst, cmd_pop && cmd_hdr.kind == CMD_DROP |=> !line_active, "wall kept line")
  `ASSERT_RST(a_beat_from_tick, clk, rst, $rose(out_valid) |-> $past(emit), "pixel without tick")
  `ASSERT_RST(a_idle_tick_silent, clk, rst, !emit && out_free |=> !out_valid, "stray pixel beat")

endmodule

@@ rtl/bresenham_line_rasterizer.sv @@
// Bresenham line stepper. A beat with s_tuser low loads a line (start, end, wall flag);
// a beat with s_tuser high is a tick that emits the next pixel of the active line on
// the master side, with tlast on the end point. Loads and ticks pass through a two-entry
// command queue to the stepper, which does one error update per clock, so a stream of
// ticks yields one pixel per cycle while m_tready does not stall the output register.
// A load with the wall flag set, or a tick while no line is active, gives no beat.
// Screen width and height set the strict clip window (0 < x < width, 0 < y < height);
// the user must write them only while the block is idle; the block does not enforce it.
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_wr_en,
  input  logic [brl_pkg::CFG_IDX_BITS-1:0]            cfg_idx,
  input  logic [brl_pkg::SCREEN_BITS-1:0]             cfg_wdata,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // start_x, start_y, end_x, end_y, end_is_wall, zero pad
  input  logic [((4*COORD_BITS+1+7)/8)*8-1:0]         s_tdata,
  // req_type
  input  logic                                        s_tuser,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // pixel_x, pixel_y, on_screen, zero pad
  output logic [((2*COORD_BITS+1+7)/8)*8-1:0]         m_tdata,
  output logic                                        m_tlast
);
  import brl_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int PAY_W = 7*C + 6;
  localparam int OUT_W = ((2*C+1+7)/8)*8;

  cmd_hdr_t               front_hdr;
  cmd_hdr_t               queue_hdr;
  logic [PAY_W-1:0]       front_payload;
  logic [PAY_W-1:0]       queue_payload;
  logic                   queue_ready;
  logic                   queue_pop;
  logic signed [C-1:0]    pixel_x;
  logic signed [C-1:0]    pixel_y;
  logic                   on_screen;

  brl_front #(.COORD_BITS(C)) u_front (
    .req_type    (s_tuser),
    .start_x     (s_tdata[C-1:0]),
    .start_y     (s_tdata[2*C-1:C]),
    .end_x       (s_tdata[3*C-1:2*C]),
    .end_y       (s_tdata[4*C-1:3*C]),
    .end_is_wall (s_tdata[4*C]),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .cmd_hdr     (front_hdr),
    .cmd_payload (front_payload),
    .cmd_ready   (queue_ready)
  );

  brl_cmd_fifo #(.DATA_BITS(PAY_W)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_hdr   (front_hdr),
    .wr_data  (front_payload),
    .wr_ready (queue_ready),
    .rd_hdr   (queue_hdr),
    .rd_data  (queue_payload),
    .rd_pop   (queue_pop)
  );

  brl_back #(.COORD_BITS(C)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .cmd_hdr     (queue_hdr),
    .cmd_payload (queue_payload),
    .cmd_pop     (queue_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .on_screen   (on_screen),
    .last_pixel  (m_tlast)
  );

  assign m_tdata = OUT_W'({on_screen, pixel_y, pixel_x});

endmodule
